### rtl/core/e1_seismic_block_decompressor_unit_macros.svh
// assertion macros for the e1 block decompressor checker
// no dependencies
`ifndef E1_SEISMIC_BLOCK_DECOMPRESSOR_UNIT_MACROS_SVH
`define E1_SEISMIC_BLOCK_DECOMPRESSOR_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define E1_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define E1_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### rtl/core/e1sbd_pkg.sv
// package for the e1 block decompressor: payload types, group tables, phase codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package e1sbd_pkg;
    localparam int MAX_ORDER = 15;
    localparam int ORD_W = 4;

    typedef struct packed {
        logic [31:0] stream_word;
        logic        stream_start;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               block_end;
        logic               check_failed;
        logic               format_error;
    } out_item_t;

    localparam logic [1:0] PH_HDR0 = 2'd0;
    localparam logic [1:0] PH_HDR1 = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    localparam logic [2:0] NO_GROUP = 3'd7;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_HDR0 = 3'd1;
    localparam logic [2:0] OP_HDR1 = 3'd2;
    localparam logic [2:0] OP_DATA = 3'd3;
    localparam logic [2:0] OP_SKIP = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       clear;
        logic       load;
        logic [2:0] op;
        logic       step;
        logic       integ;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       busy;
        logic       out_valid;
        logic       limit_hit;
        logic [1:0] phase;
    } sts_t;

    function automatic logic [2:0] grp_count(input logic [2:0] g);
        case (g)
            3'd0: grp_count = 3'd7;
            3'd1: grp_count = 3'd3;
            3'd2: grp_count = 3'd4;
            3'd3: grp_count = 3'd5;
            3'd4: grp_count = 3'd4;
            default: grp_count = 3'd1;
        endcase
    endfunction

    function automatic logic [4:0] grp_bits(input logic [2:0] g);
        case (g)
            3'd0: grp_bits = 5'd9;
            3'd1: grp_bits = 5'd10;
            3'd2: grp_bits = 5'd7;
            3'd3: grp_bits = 5'd12;
            3'd4: grp_bits = 5'd15;
            default: grp_bits = 5'd28;
        endcase
    endfunction

    function automatic logic [2:0] grp_lead(input logic [2:0] g);
        case (g)
            3'd0: grp_lead = 3'd1;
            3'd1: grp_lead = 3'd2;
            default: grp_lead = 3'd4;
        endcase
    endfunction

    function automatic logic grp_two(input logic [2:0] g);
        grp_two = (g == 3'd0) || (g == 3'd3) || (g == 3'd4);
    endfunction

    function automatic logic [2:0] classify(input logic [31:0] w);
        if (!w[31]) classify = 3'd0;
        else if (w[31:30] == 2'b10) classify = 3'd1;
        else classify = 3'd2 + {1'b0, w[29:28]};
    endfunction
endpackage
`default_nettype wire

### rtl/core/e1sbd_ctrl.sv
// controller: accepts input transactions and sequences the datapath
// depends on e1sbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module e1sbd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            in_start,
    input  wire e1sbd_pkg::sts_t sts,
    input  wire logic            out_ready,
    output e1sbd_pkg::cmd_t      cmd
);
    import e1sbd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DISP = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       integ_reg, integ_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        integ_next = 1'b0;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.clear = in_start;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.limit_hit) cmd.op = OP_NONE;
                else
                begin
                    case (sts.phase)
                        PH_HDR0: cmd.op = OP_HDR0;
                        PH_HDR1: cmd.op = OP_HDR1;
                        PH_DATA: cmd.op = OP_DATA;
                        default: cmd.op = OP_SKIP;
                    endcase
                end
                state_next = S_RUN;
            end
            S_RUN:
            begin
                // integrate, then emit; the walk holds while an emitted sample is not yet taken
                if (!sts.out_valid || out_ready)
                begin
                    if (sts.busy)
                    begin
                        if (!integ_reg)
                        begin
                            cmd.integ = 1'b1;
                            integ_next = 1'b1;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                            integ_next = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    integ_next = integ_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            integ_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            integ_reg <= integ_next;
        end
    end
endmodule
`default_nettype wire

### rtl/core/e1sbd_datapath.sv
// datapath: header fields, group unpacking, integrator cascade, output register
// depends on e1sbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module e1sbd_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire e1sbd_pkg::cmd_t      cmd,
    input  wire logic [31:0]          word,
    input  wire logic [23:0]          sample_limit,
    input  wire logic                 out_ready,
    output e1sbd_pkg::sts_t           sts,
    output e1sbd_pkg::out_item_t      out_item
);
    import e1sbd_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] bwl_reg, bwl_next;
    logic [15:0] sl_reg, sl_next;
    logic [3:0]  mode_reg, mode_next;
    logic [3:0]  ord_reg, ord_next;
    logic [23:0] chk_reg, chk_next;
    logic [31:0] held_reg, held_next;
    logic [2:0]  hg_reg, hg_next;
    logic [23:0] tot_reg, tot_next;
    logic [31:0] w_reg;
    logic [63:0] bits_reg, bits_next;
    logic [2:0]  grp_reg, grp_next;
    logic [2:0]  j_reg, j_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        raw_reg, raw_next;
    logic        err_reg, err_next;
    logic [31:0] integ_reg [MAX_ORDER];
    logic [31:0] integ_next [MAX_ORDER];
    logic [3:0]  k_reg, k_next;
    logic [31:0] v_reg, v_next;
    logic        ov_reg, ov_next;
    out_item_t   o_reg, o_next;

    logic [5:0]  sh;
    logic [63:0] shifted;
    logic [31:0] field;
    logic [31:0] mask;
    logic [4:0]  b;
    logic [31:0] raw_v;
    logic [5:0]  sh_n;
    logic [31:0] field_n;
    logic [31:0] raw_n;

    function automatic logic [3:0] ord_sat_f(input logic [3:0] o);
        ord_sat_f = (o > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : o;
    endfunction

    assign sts.busy = busy_reg;
    assign sts.out_valid = ov_reg;
    assign sts.limit_hit = (tot_reg >= sample_limit);
    assign sts.phase = phase_reg;
    assign out_item = o_reg;

    // current raw field of the group being unpacked, and the one after it
    always_comb
    begin
        b = grp_bits(grp_reg);
        sh = 6'(grp_lead(grp_reg)) + 6'(j_reg) * 6'(b);
        shifted = bits_reg << sh;
        field = 32'(shifted >> (7'd64 - 7'(b)));
        mask = 32'd1 << (b - 5'd1);
        raw_v = raw_reg ? bits_reg[63:32] : ((field ^ mask) - mask);
        sh_n = 6'(grp_lead(grp_reg)) + 6'(j_reg + 3'd1) * 6'(b);
        field_n = 32'((bits_reg << sh_n) >> (7'd64 - 7'(b)));
        raw_n = (field_n ^ mask) - mask;
    end

    always_comb
    begin
        phase_next = phase_reg; bwl_next = bwl_reg; sl_next = sl_reg;
        mode_next = mode_reg; ord_next = ord_reg; chk_next = chk_reg;
        held_next = held_reg; hg_next = hg_reg; tot_next = tot_reg;
        bits_next = bits_reg; grp_next = grp_reg; j_next = j_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; raw_next = raw_reg;
        err_next = err_reg; k_next = k_reg; v_next = v_reg;
        ov_next = ov_reg; o_next = o_reg;
        for (int i = 0; i < MAX_ORDER; i++) integ_next[i] = integ_reg[i];

        if (ov_reg && out_ready) ov_next = 1'b0;

        if (cmd.clear)
        begin
            phase_next = PH_HDR0; bwl_next = '0; sl_next = '0; mode_next = '0;
            ord_next = '0; chk_next = '0; held_next = '0; hg_next = NO_GROUP;
            tot_next = '0;
            for (int i = 0; i < MAX_ORDER; i++) integ_next[i] = '0;
        end

        case (cmd.op)
            OP_HDR0:
            begin
                if (w_reg != 32'd0)
                begin
                    bwl_next = ({2'b00, w_reg[31:18]} > 16'd2)
                        ? {2'b00, w_reg[31:18]} - 16'd2 : 16'd0;
                    sl_next = w_reg[15:0];
                    phase_next = PH_HDR1;
                end
            end
            OP_HDR1:
            begin
                mode_next = w_reg[31:28];
                ord_next = w_reg[27:24];
                chk_next = w_reg[23:0];
                for (int i = 0; i < MAX_ORDER; i++) integ_next[i] = '0;
                hg_next = NO_GROUP;
                if (w_reg[31:28] > 4'd1)
                begin
                    err_next = 1'b1;
                    busy_next = 1'b1;
                    cnt_next = 3'd1;
                    j_next = '0;
                    hg_next = NO_GROUP;
                    phase_next = (bwl_reg != 16'd0) ? PH_SKIP : PH_HDR0;
                end
                else if (sl_reg == 16'd0)
                    phase_next = (bwl_reg != 16'd0) ? PH_SKIP : PH_HDR0;
                else
                    phase_next = PH_DATA;
            end
            OP_DATA:
            begin
                if (bwl_reg != 16'd0) bwl_next = bwl_reg - 16'd1;
                j_next = '0;
                err_next = 1'b0;
                if (mode_reg == 4'd1)
                begin
                    raw_next = 1'b1;
                    bits_next = {w_reg, 32'd0};
                    cnt_next = 3'd1;
                    busy_next = 1'b1;
                end
                else if (hg_reg != NO_GROUP)
                begin
                    raw_next = 1'b0;
                    bits_next = {held_reg, w_reg};
                    grp_next = hg_reg;
                    cnt_next = grp_count(hg_reg);
                    hg_next = NO_GROUP;
                    busy_next = 1'b1;
                end
                else if (grp_two(classify(w_reg)))
                begin
                    held_next = w_reg;
                    hg_next = classify(w_reg);
                end
                else
                begin
                    raw_next = 1'b0;
                    bits_next = {w_reg, 32'd0};
                    grp_next = classify(w_reg);
                    cnt_next = grp_count(classify(w_reg));
                    busy_next = 1'b1;
                end
                // block end with no sample pending (held first half)
                if (sl_reg == 16'd0)
                begin
                    hg_next = NO_GROUP;
                    phase_next = (bwl_next != 16'd0) ? PH_SKIP : PH_HDR0;
                end
            end
            OP_SKIP:
            begin
                if (bwl_reg != 16'd0) bwl_next = bwl_reg - 16'd1;
                if (bwl_reg <= 16'd1) phase_next = PH_HDR0;
            end
            default: ;
        endcase

        // the integrator cascade is walked one stage per cycle with k, held while an output sample waits
        if (cmd.integ)
        begin
            if (err_reg) v_next = '0;
            else if (sl_reg == 16'd0 || j_reg >= cnt_reg)
            begin
                busy_next = 1'b0;
                v_next = raw_v;
            end
            else
            begin
                v_next = raw_v;
                k_next = '0;
            end
        end

        if (cmd.step)
        begin
            if (err_reg)
            begin
                if (tot_reg < sample_limit)
                begin
                    o_next.sample = '0; o_next.block_end = 1'b1;
                    o_next.check_failed = 1'b0; o_next.format_error = 1'b1;
                    ov_next = 1'b1;
                end
                busy_next = 1'b0;
                err_next = 1'b0;
            end
            else if (!raw_reg && mode_reg == 4'd0 && k_reg < ord_sat_f(ord_reg))
            begin
                integ_next[k_reg] = integ_reg[k_reg] + v_reg;
                v_next = integ_reg[k_reg] + v_reg;
                k_next = k_reg + 4'd1;
            end
            else
            begin
                sl_next = sl_reg - 16'd1;
                if (tot_reg < sample_limit)
                begin
                    o_next.sample = v_reg;
                    o_next.block_end = (sl_reg == 16'd1);
                    o_next.check_failed = (sl_reg == 16'd1) && (mode_reg == 4'd0)
                        && (v_reg != {{8{chk_reg[23]}}, chk_reg});
                    o_next.format_error = 1'b0;
                    ov_next = 1'b1;
                    tot_next = tot_reg + 24'd1;
                end
                j_next = j_reg + 3'd1;
                k_next = '0;
                if (sl_reg == 16'd1)
                begin
                    hg_next = NO_GROUP;
                    phase_next = (bwl_reg != 16'd0) ? PH_SKIP : PH_HDR0;
                end
                if (sl_reg == 16'd1 || j_reg + 3'd1 >= cnt_reg) busy_next = 1'b0;
                else v_next = raw_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) w_reg <= word;
        bits_reg <= bits_next; grp_reg <= grp_next; cnt_reg <= cnt_next;
        raw_reg <= raw_next; v_reg <= v_next; o_reg <= o_next;
        held_reg <= held_next; chk_reg <= chk_next;
        for (int i = 0; i < MAX_ORDER; i++) integ_reg[i] <= integ_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0; bwl_reg <= '0; sl_reg <= '0; mode_reg <= '0;
            ord_reg <= '0; hg_reg <= NO_GROUP; tot_reg <= '0; j_reg <= '0;
            busy_reg <= 1'b0; err_reg <= 1'b0; k_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; bwl_reg <= bwl_next; sl_reg <= sl_next;
            mode_reg <= mode_next; ord_reg <= ord_next; hg_reg <= hg_next;
            tot_reg <= tot_next; j_reg <= j_next; busy_reg <= busy_next;
            err_reg <= err_next; k_reg <= k_next; ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

### rtl/core/e1_seismic_block_decompressor_unit.sv
// e1 block decompressor, one stream word in, decoded samples out.
// in channel: in_valid/in_ready with in_data (stream_word, stream_start).
// out channel: out_valid/out_ready with out_data (sample and flags).
// apb port: register 0 at address 0 is sample_limit (24 bits, reset all ones).
// the block takes one word at a time; after acceptance it passes a
// dispatch state and a step loading the first field, then per sample one
// step for each integrator stage (order 0..15, packed mode only) and one
// step registering it at the output, and then returns to idle.
// a word yields 0 to 7 samples and holds the input until the serial walk
// over the cascade is done; no new word is taken before then.
// a waiting sample stalls the walk until the receiver takes it; no sample
// is dropped.
// reset clears all decode state, stream_start clears it except the limit.
// depends on e1sbd_pkg, e1sbd_ctrl, e1sbd_datapath
`timescale 1ns / 1ps
`default_nettype none
module e1_seismic_block_decompressor_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire e1sbd_pkg::in_item_t   in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output e1sbd_pkg::out_item_t       out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [0:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import e1sbd_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [23:0] limit_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {8'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) limit_reg <= 24'hffffff;
        else if (psel && penable && pwrite && paddr == 1'b0) limit_reg <= pwdata[23:0];
    end

    e1sbd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_start(in_data.stream_start), .sts(sts), .out_ready(out_ready), .cmd(cmd)
    );

    e1sbd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .word(in_data.stream_word),
        .sample_limit(limit_reg), .out_ready(out_ready), .sts(sts), .out_item(out_data)
    );

    assign out_valid = sts.out_valid;
endmodule
`default_nettype wire

### rtl/core/e1sbd_checker.sv
// port-level checker for the e1 block decompressor, bound to the top level
// depends on e1sbd_pkg and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "e1_seismic_block_decompressor_unit_macros.svh"
module e1sbd_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire e1sbd_pkg::out_item_t out_data
);
    import e1sbd_pkg::*;
    `E1_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `E1_ASSERT_IMPL(a_fe_end, out_valid && out_data.format_error, out_data.block_end)
    `E1_ASSERT_IMPL(a_fe_zero, out_valid && out_data.format_error, out_data.sample == 0)
    `E1_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)
    `E1_ASSERT_IMPL(a_cf_end, out_valid && out_data.check_failed, out_data.block_end)
endmodule
bind e1_seismic_block_decompressor_unit e1sbd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

### tb/e1_decode_checker.sv
// checker for the e1 block decompressor: watches both channels, predicts samples
// from accepted stream words and compares them in order; depends on e1sbd_pkg
`timescale 1ns / 1ps
module e1_decode_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  e1sbd_pkg::in_item_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  e1sbd_pkg::out_item_t out_data,
    input  logic                 limit_we,
    input  logic [23:0]          limit_value,
    output int                   fail_count,
    output int                   pending_count
);
    import e1sbd_pkg::*;

    localparam int N_GROUPS = 6;
    localparam int GCOUNT [N_GROUPS] = '{7, 3, 4, 5, 4, 1};
    localparam int GWORDS [N_GROUPS] = '{2, 1, 1, 2, 2, 1};
    localparam int GBITS  [N_GROUPS] = '{9, 10, 7, 12, 15, 28};
    localparam int GLEAD  [N_GROUPS] = '{1, 2, 4, 4, 4, 4};
    localparam logic [3:0] MODE_PACKED = 4'd0;
    localparam logic [3:0] MODE_RAW    = 4'd1;

    out_item_t   sample_q[$];
    logic [23:0] limit_r;
    logic [1:0]  ph;
    logic [31:0] words_left, samples_left, emitted;
    logic [3:0]  mode_r, order_r;
    logic [23:0] check_r;
    logic [31:0] held_w;
    logic [2:0]  held_g;
    logic [31:0] integ [MAX_ORDER];

    assign pending_count = sample_q.size();

    task automatic clear_decode();
        ph = PH_HDR0;
        words_left = 0;
        samples_left = 0;
        mode_r = 0;
        order_r = 0;
        check_r = 0;
        held_w = 0;
        held_g = NO_GROUP;
        emitted = 0;
        for (int k = 0; k < MAX_ORDER; k++) integ[k] = 0;
    endtask

    task automatic push_result(logic [31:0] s, logic e, logic cf, logic fe);
        out_item_t r;
        r.sample = s;
        r.block_end = e;
        r.check_failed = cf;
        r.format_error = fe;
        sample_q.push_back(r);
    endtask

    task automatic integrate_sample(logic [31:0] raw);
        logic [31:0] v;
        logic        last, cf;
        logic [31:0] chk;
        v = raw;
        cf = 0;
        if (samples_left == 0) return;
        if (mode_r == MODE_PACKED)
            for (int k = 0; k < order_r; k++)
            begin
                integ[k] = integ[k] + v;
                v = integ[k];
            end
        samples_left--;
        last = (samples_left == 0);
        if (last && mode_r == MODE_PACKED)
        begin
            chk = {{8{check_r[23]}}, check_r};
            cf = (chk != v);
        end
        if (emitted < limit_r)
        begin
            push_result(v, last, cf, 1'b0);
            emitted++;
        end
    endtask

    task automatic finish_block();
        held_g = NO_GROUP;
        ph = (words_left != 0) ? PH_SKIP : PH_HDR0;
    endtask

    task automatic unpack_group(int g, logic [63:0] bits);
        logic [63:0] sh;
        logic [31:0] f;
        for (int j = 0; j < GCOUNT[g] && samples_left > 0; j++)
        begin
            sh = bits << (GLEAD[g] + j * GBITS[g]);
            f = 32'(sh >> (64 - GBITS[g]));
            f = (f ^ (32'd1 << (GBITS[g] - 1))) - (32'd1 << (GBITS[g] - 1));
            integrate_sample(f);
        end
    endtask

    function automatic int group_of(logic [31:0] w);
        if (w[31:28] < 4'h8) return 0;
        if (w[31:28] < 4'hc) return 1;
        return 2 + w[29:28];
    endfunction

    task automatic decode_word(in_item_t it);
        logic [31:0] w, nw;
        int          g;
        w = it.stream_word;
        if (it.stream_start) clear_decode();
        if (emitted >= limit_r) return;
        case (ph)
            PH_HDR0:
            begin
                if (w == 0) return;
                nw = {18'd0, w[31:18]};
                words_left = (nw > 2) ? nw - 2 : 0;
                samples_left = {16'd0, w[15:0]};
                ph = PH_HDR1;
            end
            PH_HDR1:
            begin
                mode_r = w[31:28];
                order_r = w[27:24];
                check_r = w[23:0];
                for (int k = 0; k < MAX_ORDER; k++) integ[k] = 0;
                held_g = NO_GROUP;
                if (mode_r > MODE_RAW)
                begin
                    push_result(0, 1'b1, 1'b0, 1'b1);
                    finish_block();
                end
                else if (samples_left == 0) finish_block();
                else ph = PH_DATA;
            end
            PH_DATA:
            begin
                if (words_left > 0) words_left--;
                if (mode_r == MODE_RAW) integrate_sample(w);
                else if (held_g < 6)
                begin
                    g = held_g;
                    held_g = NO_GROUP;
                    unpack_group(g, {held_w, w});
                end
                else
                begin
                    g = group_of(w);
                    if (GWORDS[g] == 2)
                    begin
                        held_w = w;
                        held_g = 3'(g);
                    end
                    else unpack_group(g, {w, 32'd0});
                end
                if (samples_left == 0) finish_block();
            end
            default:
            begin
                if (words_left > 0) words_left--;
                if (words_left == 0) ph = PH_HDR0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            limit_r = 24'hffffff;
            clear_decode();
            sample_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (limit_we) limit_r = limit_value;
            if (out_valid && out_ready)
            begin
                if (sample_q.size() == 0)
                begin
                    $error("unexpected transaction: sample %0d", out_data.sample);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = sample_q.pop_front();
                    if (exp_r != out_data)
                    begin
                        fail_count <= fail_count + 1;
                        if (exp_r.sample != out_data.sample)
                            $error("sample: expected %0d, got %0d",
                                   exp_r.sample, out_data.sample);
                        if (exp_r.block_end != out_data.block_end)
                            $error("block_end: expected %0d, got %0d",
                                   exp_r.block_end, out_data.block_end);
                        if (exp_r.check_failed != out_data.check_failed)
                            $error("check_failed: expected %0d, got %0d",
                                   exp_r.check_failed, out_data.check_failed);
                        if (exp_r.format_error != out_data.format_error)
                            $error("format_error: expected %0d, got %0d",
                                   exp_r.format_error, out_data.format_error);
                    end
                end
            end
            if (in_valid && in_ready) decode_word(in_data);
        end
    end
endmodule

### tb/testbench.sv
// stimulus and verdict for the e1 block decompressor: directed blocks, random
// well-formed and broken streams, limit settings; depends on e1sbd_pkg, checker
`timescale 1ns / 1ps
module testbench;
    import e1sbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [0:0] ADDR_SAMPLE_LIMIT = 1'b0;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_item_t   out_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [0:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending_count;
    int          cycles = 0;
    int          burst_left = 0;
    logic        limit_we;

    always #1 clk = ~clk;

    e1_seismic_block_decompressor_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    assign limit_we = psel && penable && pwrite && pready && paddr == ADDR_SAMPLE_LIMIT;

    e1_decode_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .limit_we(limit_we), .limit_value(pwdata[23:0]),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver stall pattern: mostly ready, with quiet and stalling stretches
    always @(negedge clk)
    begin
        int mode_sel;
        mode_sel = (cycles / 500) % 3;
        if (mode_sel == 0) out_ready <= 1'b1;
        else if (mode_sel == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 1) != 0);
    end

    // valid stays up between words of a burst, the payload moves to the next word
    task automatic send_word(logic [31:0] w, logic st = 1'b0);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data.stream_word <= w;
        in_data.stream_start <= st;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(logic [23:0] v);
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        psel <= 1; pwrite <= 1; paddr <= ADDR_SAMPLE_LIMIT; pwdata <= {8'd0, v};
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    function automatic logic [31:0] hdr0(int nwords, int nsamp);
        return {16'(nwords * 4 + $urandom_range(0, 3)), 16'(nsamp)};
    endfunction

    // data word for a group, random payload with the right prefix
    function automatic logic [31:0] group_word(int g);
        logic [31:0] r;
        r = $urandom;
        case (g)
            0: r[31] = 1'b0;
            1: r[31:30] = 2'b10;
            default: r[31:28] = 4'hc + 4'(g - 2);
        endcase
        return r;
    endfunction

    // one random mode 0 block; returns after sending all its words
    task automatic packed_block(int nsamp, logic [3:0] ord, logic st, int extra);
        int          g, got, nw;
        logic [31:0] d[$];
        got = 0;
        while (got < nsamp)
        begin
            g = $urandom_range(0, 5);
            d.push_back(group_word(g));
            if (g == 0 || g == 3 || g == 4) d.push_back($urandom);
            got += (g == 0) ? 7 : (g == 1) ? 3 : (g == 3) ? 5 : (g == 5) ? 1 : 4;
        end
        nw = d.size() + 2 + extra;
        send_word(hdr0(nw, nsamp), st);
        send_word({4'd0, ord, 24'($urandom)});
        foreach (d[i]) send_word(d[i]);
        repeat (extra) send_word($urandom);
    endtask

    task automatic raw_block(int nsamp, logic st, int extra);
        send_word(hdr0(nsamp + 2 + extra, nsamp), st);
        send_word({4'd1, 4'($urandom), 24'($urandom)});
        repeat (nsamp) send_word($urandom);
        repeat (extra) send_word($urandom);
    endtask

    initial
    begin
        int pick;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extreme groups, orders, raw, bad mode, padding, zero count
        send_word(32'h0, 1'b1);
        send_word(32'h0);
        send_word(hdr0(4, 7));
        send_word({4'd0, 4'd15, 24'h800000});
        send_word(32'h7fff_ffff);
        send_word(32'hffff_ffff);
        send_word(hdr0(3, 1));
        send_word({4'd0, 4'd0, 24'h7fffff});
        send_word(32'hffff_ffff);
        send_word(hdr0(3, 2));
        send_word({4'd1, 4'd0, 24'h0});
        send_word(32'h8000_0000);
        send_word(32'h7fff_ffff);
        send_word(hdr0(6, 0));
        send_word({4'hf, 4'hf, 24'hffffff});
        repeat (4) send_word($urandom);
        send_word(hdr0(2, 0));
        send_word({4'd0, 4'd3, 24'd0});
        send_word(hdr0(3, 3));
        send_word({4'd0, 4'd1, 24'h000000});
        send_word(32'hb000_0001);
        send_word({16'hffff, 16'hffff}, 1'b1);
        send_word({4'd2, 4'd0, 24'd0});

        write_limit(24'd0);
        raw_block(3, 1'b1, 0);
        write_limit(24'd5);
        packed_block(12, 4'd2, 1'b1, 1);
        write_limit(24'hffffff);

        for (int i = 0; i < 11; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                packed_block(($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12),
                             4'($urandom), ($urandom_range(0, 9) == 0),
                             $urandom_range(0, 2));
            else if (pick < 8) raw_block($urandom_range(1, 5), 1'b0, $urandom_range(0, 1));
            else if (pick == 8) send_word($urandom, $urandom_range(0, 1));
            else
            begin
                send_word(32'h0);
                send_word(hdr0($urandom_range(2, 4), $urandom_range(0, 3)));
                send_word({4'($urandom_range(2, 15)), 28'($urandom)});
            end
            if (i == 5) write_limit(24'($urandom_range(20, 60)));
        end
        write_limit(24'd1);
        packed_block(5, 4'd1, 1'b1, 0);

        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
